// File: hdl/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasterizer package
// Opcodes, the colour width and the queue depth shared by the channels and the rasterizer modules.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int COLOUR_W    = 3;
  localparam int QUEUE_DEPTH = 2;

endpackage

// File: hdl/lr_if.sv
// ----------------------------------------------------------------------------
// Line rasterizer channels
// Valid/ready channels for segment commands and for emitted pixels.
// ----------------------------------------------------------------------------
interface lr_in_if #(
  parameter int CW = 12
);
  import lr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic signed [CW-1:0] x_start;
  logic signed [CW-1:0] y_start;
  logic signed [CW-1:0] x_end;
  logic signed [CW-1:0] y_end;
  logic [COLOUR_W-1:0]  colour;

  modport source (output valid, opcode, x_start, y_start, x_end, y_end, colour,
                  input ready);
  modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, colour,
                  output ready);
endinterface

interface lr_out_if #(
  parameter int CW = 12
);
  import lr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pixel_x;
  logic signed [CW-1:0] pixel_y;
  logic [COLOUR_W-1:0]  pixel_colour;
  logic                 last;

  modport source (output valid, pixel_x, pixel_y, pixel_colour, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_colour, last, output ready);
endinterface

// File: hdl/lr_front.sv
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accept commands, work out the major/minor axis setup for loads and push every command.
// ----------------------------------------------------------------------------
module lr_front #(
  parameter int CW    = 12,
  parameter int CMD_W = 5 * CW + 6
) (
  lr_in_if.sink            in_ch,
  output logic             cmd_push,
  output logic [CMD_W-1:0] cmd_data,
  input  logic             cmd_full
);
  import lr_pkg::*;

  typedef struct packed {
    logic                 is_load;
    logic                 major_is_y;
    logic signed [CW-1:0] major_start;
    logic signed [CW-1:0] major_stop;
    logic signed [CW-1:0] minor_start;
    logic [CW-1:0]        delta_major;
    logic signed [CW:0]   delta_minor;
    logic [COLOUR_W-1:0]  colour;
  } cmd_t;

  logic signed [CW:0]   dx, dy, adx, ady, dmaj_s, dmin_s;
  logic signed [CW:0]   dmaj_abs, dmin_adj;
  logic signed [CW-1:0] ms, me, ns, ne;
  logic                 major_y, flip;
  cmd_t                 cmd;

  assign in_ch.ready = !cmd_full;
  assign cmd_push    = in_ch.valid && !cmd_full;

  always_comb begin
    dx = {in_ch.x_end[CW-1], in_ch.x_end} - {in_ch.x_start[CW-1], in_ch.x_start};
    dy = {in_ch.y_end[CW-1], in_ch.y_end} - {in_ch.y_start[CW-1], in_ch.y_start};
    adx = dx[CW] ? -dx : dx;
    ady = dy[CW] ? -dy : dy;
    major_y = !(adx > ady);
    if (major_y) begin
      ms = in_ch.y_start; me = in_ch.y_end; ns = in_ch.x_start; ne = in_ch.x_end;
      dmaj_s = dy; dmin_s = dx;
    end else begin
      ms = in_ch.x_start; me = in_ch.x_end; ns = in_ch.y_start; ne = in_ch.y_end;
      dmaj_s = dx; dmin_s = dy;
    end
    flip     = dmaj_s[CW];
    dmaj_abs = flip ? -dmaj_s : dmaj_s;
    dmin_adj = flip ? -dmin_s : dmin_s;

    cmd.is_load     = (in_ch.opcode == OP_LOAD);
    cmd.major_is_y  = major_y;
    cmd.major_start = flip ? me : ms;
    cmd.major_stop  = flip ? ms : me;
    cmd.minor_start = flip ? ne : ns;
    cmd.delta_major = dmaj_abs[CW-1:0];
    cmd.delta_minor = dmin_adj;
    cmd.colour      = in_ch.colour;
  end

  assign cmd_data = cmd;

endmodule

// File: hdl/lr_queue.sv
// ----------------------------------------------------------------------------
// Line rasterizer command queue
// Small FIFO that decouples the front end from the pixel stepper.
// ----------------------------------------------------------------------------
module lr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign full      = (count_r == CNTW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("queue read while empty");

endmodule

// File: hdl/lr_back.sv
// ----------------------------------------------------------------------------
// Line rasterizer back end
// Hold the current segment, step the major axis once per tick and keep the
// minor coordinate as quotient and remainder over the major delta.
// ----------------------------------------------------------------------------
module lr_back #(
  parameter int CW    = 12,
  parameter int CMD_W = 5 * CW + 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  lr_out_if.source         out_ch
);
  import lr_pkg::*;

  typedef struct packed {
    logic                 is_load;
    logic                 major_is_y;
    logic signed [CW-1:0] major_start;
    logic signed [CW-1:0] major_stop;
    logic signed [CW-1:0] minor_start;
    logic [CW-1:0]        delta_major;
    logic signed [CW:0]   delta_minor;
    logic [COLOUR_W-1:0]  colour;
  } cmd_t;

  cmd_t cmd;

  logic                 active_r, active_nxt;
  logic                 major_is_y_r;
  logic signed [CW-1:0] major_pos_r, major_stop_r;
  logic signed [CW-1:0] quo_r;
  logic [CW-1:0]        rem_r;
  logic [CW-1:0]        dmaj_r;
  logic signed [CW:0]   dmin_r;
  logic [COLOUR_W-1:0]  colour_r;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [COLOUR_W-1:0]  out_colour_r;
  logic                 out_last_r;

  logic                 out_free, emit, fin;
  logic signed [CW:0]   major_next, stop_ext;
  logic signed [CW+1:0] rem_sum, dmaj_ext;
  logic signed [CW-1:0] minor;
  logic signed [CW-1:0] quo_step;
  logic [CW-1:0]        rem_step;

  assign cmd = cmd_t'(cmd_data);

  assign out_free = !out_valid_r || out_ch.ready;
  assign cmd_pop  = cmd_valid && (cmd.is_load || !active_r || out_free);
  assign emit     = cmd_pop && !cmd.is_load && active_r;

  always_comb begin
    major_next = {major_pos_r[CW-1], major_pos_r} + (CW+1)'(1);
    stop_ext   = {major_stop_r[CW-1], major_stop_r};
    fin        = (major_next >= stop_ext);
    minor      = quo_r + {{(CW-1){1'b0}}, (quo_r[CW-1] && (rem_r != '0))};

    rem_sum  = $signed({2'b00, rem_r}) + {dmin_r[CW], dmin_r};
    dmaj_ext = $signed({2'b00, dmaj_r});
    if (rem_sum >= dmaj_ext) begin
      rem_step = CW'(rem_sum - dmaj_ext);
      quo_step = quo_r + {{(CW-1){1'b0}}, 1'b1};
    end else if (rem_sum[CW+1]) begin
      rem_step = CW'(rem_sum + dmaj_ext);
      quo_step = quo_r - {{(CW-1){1'b0}}, 1'b1};
    end else begin
      rem_step = rem_sum[CW-1:0];
      quo_step = quo_r;
    end

    active_nxt = active_r;
    if (cmd_pop && cmd.is_load) begin
      active_nxt = (cmd.delta_major != '0);
    end else if (emit && fin) begin
      active_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_load) begin
      major_is_y_r <= cmd.major_is_y;
      major_pos_r  <= cmd.major_start;
      major_stop_r <= cmd.major_stop;
      quo_r        <= cmd.minor_start;
      rem_r        <= '0;
      dmaj_r       <= cmd.delta_major;
      dmin_r       <= cmd.delta_minor;
      colour_r     <= cmd.colour;
    end else if (emit) begin
      major_pos_r <= major_next[CW-1:0];
      quo_r       <= quo_step;
      rem_r       <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r      <= major_is_y_r ? minor : major_pos_r;
      out_y_r      <= major_is_y_r ? major_pos_r : minor;
      out_colour_r <= colour_r;
      out_last_r   <= fin;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.pixel_colour = out_colour_r;
  assign out_ch.last         = out_last_r;

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (rem_r < dmaj_r))
    else $error("minor remainder out of range");

  a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
    emit && fin |=> !active_r && out_ch.valid && out_ch.last)
    else $error("final pixel did not end the segment");

  a_no_emit_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !emit)
    else $error("pixel emitted over a held pixel");

  a_degenerate_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.is_load && (cmd.delta_major == '0) |=> !active_r)
    else $error("degenerate segment left active");

endmodule

// File: hdl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// Line rasterizer
// Walks a line segment along its major axis, one pixel per tick command.
//
// in_ch carries commands: opcode OP_LOAD latches two endpoints and a colour
// and emits nothing; opcode OP_TICK emits the next pixel of the segment, or
// nothing once the segment is exhausted or was degenerate. out_ch carries
// pixels with the latched colour; last marks the final pixel.
// A transaction on in_ch enters a two-entry command queue; the stepper takes
// one command per cycle unless a held pixel stops a tick. A tick's pixel
// goes through the queue and the output register to out_ch. Sustained
// throughput is one pixel per cycle while out_ch is ready. A load is popped
// too but emits no pixel. The minor coordinate is kept as quotient and
// remainder over the major delta, updated by one add and compare per pixel.
// When out_ch stalls, the held pixel stays in the output register, the
// stepper stops on the next tick, and in_ch drops ready once the queue fills.
// Reset clears the queue, the output valid flag and the active segment.
// ----------------------------------------------------------------------------
module line_rasterizer #(
  parameter int COORD_WIDTH = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  lr_in_if.sink     in_ch,
  lr_out_if.source  out_ch
);
  import lr_pkg::*;

  localparam int CMD_W = 5 * COORD_WIDTH + 3 + COLOUR_W;

  logic             cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic [CMD_W-1:0] cmd_in, cmd_out;

  lr_front #(
    .CW    (COORD_WIDTH),
    .CMD_W (CMD_W)
  ) u_front (
    .in_ch    (in_ch),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  lr_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .not_empty (cmd_valid)
  );

  lr_back #(
    .CW    (COORD_WIDTH),
    .CMD_W (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule
